### sv/crcd_pkg.sv
package crcd_pkg;

	typedef enum logic [1:0] {
		KIND_CHAR = 2'd0,
		KIND_HEX  = 2'd1,
		KIND_B64  = 2'd2,
		KIND_END  = 2'd3
	} kind_t;

	typedef enum logic [1:0] {
		MODE_PLAIN = 2'd0,
		MODE_HEX   = 2'd1,
		MODE_B64   = 2'd2
	} mode_t;

	typedef enum logic [2:0] {
		ST_BYTE     = 3'd0,
		ST_CLOSED   = 3'd1,
		ST_LEFTOVER = 3'd2,
		ST_ILLEGAL  = 3'd3,
		ST_END      = 3'd4
	} status_t;

	localparam logic [7:0] CH_BAR   = 8'h7C;
	localparam logic [7:0] CH_BRACE = 8'h7D;
	localparam logic [7:0] CH_HASH  = 8'h23;
	localparam logic [7:0] CH_PAD   = 8'h3D;

	localparam int unsigned BUF_W = 12;
	localparam int unsigned CNT_W = 4;
	localparam logic [CNT_W-1:0] CNT_MAX  = 4'd12;
	localparam logic [CNT_W-1:0] CNT_BYTE = 4'd8;
	localparam logic [CNT_W-1:0] HEX_BITS = 4'd4;
	localparam logic [CNT_W-1:0] B64_BITS = 4'd6;

	typedef struct packed {
		logic       skip;
		logic       close;
		logic       digit;
		logic [5:0] value;
	} class_t;

	typedef struct packed {
		logic       emit;
		status_t    status;
		logic [7:0] data;
	} res_t;

endpackage

### sv/crcd_if.sv
interface crcd_item_if;
	logic       valid;
	logic       ready;
	logic [1:0] kind;
	logic [7:0] char_in;

	modport source (output valid, output kind, output char_in, input ready);
	modport sink (input valid, input kind, input char_in, output ready);
endinterface

interface crcd_result_if;
	logic       valid;
	logic       ready;
	logic [2:0] status;
	logic [7:0] byte_out;

	modport source (output valid, output status, output byte_out, input ready);
	modport sink (input valid, input status, input byte_out, output ready);
endinterface

### sv/crcd_classify.sv
module crcd_classify
	import crcd_pkg::*;
(
	input  mode_t      mode,
	input  logic [7:0] ch,
	output class_t     cls
);

	logic is_space;

	assign is_space = (ch == 8'h20) || (ch == 8'h09) || (ch == 8'h0A) ||
		(ch == 8'h0B) || (ch == 8'h0C) || (ch == 8'h0D);

	always_comb begin
		cls.skip  = is_space || (mode == MODE_B64 && ch == CH_PAD);
		cls.close = (mode == MODE_B64 && (ch == CH_BAR || ch == CH_BRACE)) ||
			(mode == MODE_HEX && ch == CH_HASH);
		cls.digit = 1'b0;
		cls.value = 6'd0;
		if (mode == MODE_HEX) begin
			if (ch >= 8'h30 && ch <= 8'h39) begin
				cls.digit = 1'b1;
				cls.value = 6'(ch - 8'h30);
			end else if (ch >= 8'h41 && ch <= 8'h46) begin
				cls.digit = 1'b1;
				cls.value = 6'(ch - 8'h41 + 8'd10);
			end else if (ch >= 8'h61 && ch <= 8'h66) begin
				cls.digit = 1'b1;
				cls.value = 6'(ch - 8'h61 + 8'd10);
			end
		end else begin
			if (ch >= 8'h41 && ch <= 8'h5A) begin
				cls.digit = 1'b1;
				cls.value = 6'(ch - 8'h41);
			end else if (ch >= 8'h61 && ch <= 8'h7A) begin
				cls.digit = 1'b1;
				cls.value = 6'(ch - 8'h61 + 8'd26);
			end else if (ch >= 8'h30 && ch <= 8'h39) begin
				cls.digit = 1'b1;
				cls.value = 6'(ch - 8'h30 + 8'd52);
			end else if (ch == 8'h2B) begin
				cls.digit = 1'b1;
				cls.value = 6'd62;
			end else if (ch == 8'h2F) begin
				cls.digit = 1'b1;
				cls.value = 6'd63;
			end
		end
	end

endmodule

### sv/crcd_core.sv
module crcd_core
	import crcd_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       fire,
	input  kind_t      kind,
	input  logic [7:0] ch,
	output res_t       res
);

	mode_t             mode_q, mode_d;
	logic [BUF_W-1:0]  buf_q, buf_d;
	logic [CNT_W-1:0]  cnt_q, cnt_d;
	class_t            cls;
	logic [BUF_W-1:0]  buf_sh;
	logic [BUF_W-1:0]  mask;
	logic [CNT_W:0]    cnt_sum;
	logic [CNT_W-1:0]  cnt_w;
	logic [CNT_W-1:0]  shamt;
	logic [BUF_W-1:0]  byte_sh;

	crcd_classify u_classify (
		.mode (mode_q),
		.ch   (ch),
		.cls  (cls)
	);

	always_comb begin
		if (mode_q == MODE_HEX) begin
			buf_sh  = {buf_q[BUF_W-5:0], cls.value[3:0]};
			cnt_sum = {1'b0, cnt_q} + {1'b0, HEX_BITS};
		end else begin
			buf_sh  = {buf_q[BUF_W-7:0], cls.value};
			cnt_sum = {1'b0, cnt_q} + {1'b0, B64_BITS};
		end
		cnt_w   = (cnt_sum[CNT_W-1:0] > CNT_MAX) ? CNT_MAX : cnt_sum[CNT_W-1:0];
		shamt   = cnt_w - CNT_BYTE;
		byte_sh = buf_sh >> shamt;
		mask    = (cnt_q >= CNT_MAX) ? {BUF_W{1'b1}} :
			BUF_W'((13'd1 << cnt_q) - 13'd1);
	end

	always_comb begin
		mode_d     = mode_q;
		buf_d      = buf_q;
		cnt_d      = cnt_q;
		res.emit   = 1'b0;
		res.status = ST_BYTE;
		res.data   = ch;
		case (kind)
			KIND_HEX: begin
				mode_d = MODE_HEX;
				buf_d  = '0;
				cnt_d  = '0;
			end
			KIND_B64: begin
				mode_d = MODE_B64;
				buf_d  = '0;
				cnt_d  = '0;
			end
			KIND_END: begin
				mode_d     = MODE_PLAIN;
				buf_d      = '0;
				cnt_d      = '0;
				res.emit   = 1'b1;
				res.status = ST_END;
				res.data   = 8'd0;
			end
			default: begin
				if (mode_q != MODE_HEX && mode_q != MODE_B64) begin
					res.emit = 1'b1;
				end else if (cls.close) begin
					mode_d     = MODE_PLAIN;
					buf_d      = '0;
					cnt_d      = '0;
					res.emit   = 1'b1;
					res.status = ((buf_q & mask) != '0) ? ST_LEFTOVER : ST_CLOSED;
				end else if (cls.skip) begin
					res.emit = 1'b0;
				end else if (!cls.digit) begin
					res.emit   = 1'b1;
					res.status = ST_ILLEGAL;
				end else begin
					buf_d = buf_sh;
					cnt_d = cnt_w;
					if (cnt_w >= CNT_BYTE) begin
						cnt_d    = shamt;
						res.emit = 1'b1;
						res.data = byte_sh[7:0];
					end
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_PLAIN;
			buf_q  <= '0;
			cnt_q  <= '0;
		end else if (fire) begin
			mode_q <= mode_d;
			buf_q  <= buf_d;
			cnt_q  <= cnt_d;
		end
	end

	// a full byte never stays pending
	a_cnt_below_byte: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q < CNT_BYTE)
		else $error("bit count holds a full byte");

	a_plain_empty: assert property (@(posedge clk) disable iff (!arst_n)
		mode_q == MODE_PLAIN |-> (cnt_q == '0 && buf_q == '0))
		else $error("pending bits in plain mode");

	a_end_to_plain: assert property (@(posedge clk) disable iff (!arst_n)
		(fire && kind == KIND_END) |=> (mode_q == MODE_PLAIN && cnt_q == '0))
		else $error("end of input left a region open");

	a_open_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(fire && (kind == KIND_HEX || kind == KIND_B64)) |=>
		(cnt_q == '0 && buf_q == '0 && mode_q != MODE_PLAIN))
		else $error("open command did not start an empty region");

endmodule

### sv/coded_region_char_decoder.sv
// channel   dir   payload                  handshake
// item      in    kind[1:0] char_in[7:0]   valid/ready
// result    out   status[2:0] byte_out[7:0] valid/ready
//
// one request per cycle sustained, unless a waiting result stalls a request that makes a result
// the input register feeds one decode step into the result register
// arst_n clears the region state to plain mode and drops both valid flags
// a waiting result stalls only a request that makes a result

module coded_region_char_decoder
	import crcd_pkg::*;
(
	input logic              clk,
	input logic              arst_n,
	crcd_item_if.sink        item,
	crcd_result_if.source    result
);

	logic       valid_s1;
	kind_t      kind_s1;
	logic [7:0] char_s1;
	logic       out_valid_q;
	status_t    status_q;
	logic [7:0] byte_q;
	res_t       res;
	logic       fire;

	crcd_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.fire   (fire),
		.kind   (kind_s1),
		.ch     (char_s1),
		.res    (res)
	);

	assign fire       = valid_s1 && (!res.emit || !out_valid_q || result.ready);
	assign item.ready = !valid_s1 || fire;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item.ready) begin
			valid_s1 <= item.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item.ready && item.valid) begin
			kind_s1 <= kind_t'(item.kind);
			char_s1 <= item.char_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fire && res.emit) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire && res.emit) begin
			status_q <= res.status;
			byte_q   <= res.data;
		end
	end

	assign result.valid    = out_valid_q;
	assign result.status   = status_q;
	assign result.byte_out = byte_q;

endmodule

### sim/decoder_checker.sv
module decoder_checker
	import crcd_pkg::*;
(
	input logic     clk,
	input logic     arst_n,
	crcd_item_if    item,
	crcd_result_if  result,
	output int      errors,
	output int      pending
);

	typedef struct packed {
		status_t    status;
		logic [7:0] data;
	} decoded_t;

	decoded_t         decoded_q[$];
	mode_t            region;
	logic [BUF_W-1:0] bits;
	logic [CNT_W-1:0] nbits;

	initial begin
		errors = 0;
		pending = 0;
	end

	task automatic decode_request(input kind_t k, input logic [7:0] c);
		logic [5:0]       digit;
		logic             legal;
		logic [CNT_W-1:0] width;
		logic [CNT_W-1:0] sum;
		logic [BUF_W-1:0] mask;
		status_t          st;
		digit = '0;
		legal = 1'b1;
		if (k == KIND_HEX || k == KIND_B64) begin
			region = (k == KIND_HEX) ? MODE_HEX : MODE_B64;
			bits = '0;
			nbits = '0;
		end else if (k == KIND_END) begin
			region = MODE_PLAIN;
			bits = '0;
			nbits = '0;
			decoded_q.push_back('{ST_END, 8'h00});
		end else if (region != MODE_HEX && region != MODE_B64) begin
			decoded_q.push_back('{ST_BYTE, c});
		end else if ((region == MODE_B64 && (c == CH_BAR || c == CH_BRACE)) ||
				(region == MODE_HEX && c == CH_HASH)) begin
			mask = ~({BUF_W{1'b1}} << nbits);
			st = ((bits & mask) != '0) ? ST_LEFTOVER : ST_CLOSED;
			decoded_q.push_back('{st, c});
			region = MODE_PLAIN;
			bits = '0;
			nbits = '0;
		end else if (!(c == 8'h20 || (c >= 8'h09 && c <= 8'h0D)) &&
				!(region == MODE_B64 && c == CH_PAD)) begin
			if (region == MODE_HEX) begin
				width = HEX_BITS;
				if (c >= "0" && c <= "9") digit = 6'(c - "0");
				else if (c >= "A" && c <= "F") digit = 6'(c - "A" + 10);
				else if (c >= "a" && c <= "f") digit = 6'(c - "a" + 10);
				else legal = 1'b0;
			end else begin
				width = B64_BITS;
				if (c >= "A" && c <= "Z") digit = 6'(c - "A");
				else if (c >= "a" && c <= "z") digit = 6'(c - "a" + 26);
				else if (c >= "0" && c <= "9") digit = 6'(c - "0" + 52);
				else if (c == "+") digit = 6'd62;
				else if (c == "/") digit = 6'd63;
				else legal = 1'b0;
			end
			if (!legal) begin
				decoded_q.push_back('{ST_ILLEGAL, c});
			end else begin
				bits = (bits << width) | BUF_W'(digit);
				sum = nbits + width;
				nbits = (sum > CNT_MAX) ? CNT_MAX : sum;
				if (nbits >= CNT_BYTE) begin
					decoded_q.push_back('{ST_BYTE, 8'(bits >> (nbits - CNT_BYTE))});
					nbits = nbits - CNT_BYTE;
				end
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin : watch
		decoded_t want;
		if (!arst_n) begin
			region = MODE_PLAIN;
			bits = '0;
			nbits = '0;
			decoded_q.delete();
			pending = 0;
		end else begin
			if (result.valid && result.ready) begin
				if (decoded_q.size() == 0) begin
					errors++;
					$display("%0t: result with none expected, actual status %0d byte %h",
						$time, result.status, result.byte_out);
				end else begin
					want = decoded_q.pop_front();
					if (result.status !== want.status) begin
						errors++;
						$display("%0t: status expected %0d actual %0d",
							$time, want.status, result.status);
					end
					if (result.byte_out !== want.data) begin
						errors++;
						$display("%0t: byte expected %h actual %h",
							$time, want.data, result.byte_out);
					end
				end
			end
			if (item.valid && item.ready)
				decode_request(kind_t'(item.kind), item.char_in);
			pending = decoded_q.size();
		end
	end

endmodule

### sim/testbench.sv
module testbench
	import crcd_pkg::*;
();

	logic  clk = 1'b0;
	logic  arst_n = 1'b0;
	int    errors;
	int    pending;
	int    counted = 0;
	int    hold_cycles = 0;
	bit    calm = 1'b0;
	string hex_digits = "0123456789abcdefABCDEF";
	string b64_digits = "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

	crcd_item_if   item ();
	crcd_result_if result ();

	coded_region_char_decoder DUT (
		.clk,
		.arst_n,
		.item   (item),
		.result (result)
	);

	decoder_checker u_checker (
		.clk,
		.arst_n,
		.item    (item),
		.result  (result),
		.errors  (errors),
		.pending (pending)
	);

	always #5 clk = ~clk;

	initial begin
		#3000000;
		$display("RESULT: ERROR");
		$finish;
	end

	task automatic send_item(input kind_t k, input logic [7:0] c);
		int gap;
		gap = calm ? 0 : $urandom_range(0, 12);
		if (gap > 0) begin
			item.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		item.valid <= 1'b1;
		item.kind <= k;
		item.char_in <= c;
		@(posedge clk);
		while (!item.ready) @(posedge clk);
		counted++;
	endtask

	task automatic send_region(input kind_t k);
		int         n;
		int         r;
		logic [7:0] c;
		send_item(k, 8'($urandom));
		n = $urandom_range(0, 12);
		repeat (n) begin
			r = $urandom_range(0, 19);
			if (r < 2)
				c = ($urandom_range(0, 5) == 0) ? 8'h20 : 8'(9 + $urandom_range(0, 4));
			else if (r == 2)
				c = (k == KIND_B64) ? CH_PAD : 8'($urandom);
			else if (r == 3)
				c = 8'($urandom);
			else if (k == KIND_HEX)
				c = hex_digits[$urandom_range(0, hex_digits.len() - 1)];
			else
				c = b64_digits[$urandom_range(0, b64_digits.len() - 1)];
			send_item(KIND_CHAR, c);
		end
		r = $urandom_range(0, 9);
		if (r == 0)
			send_item(KIND_END, 8'($urandom));
		else if (r == 1)
			;
		else if (k == KIND_HEX)
			send_item(KIND_CHAR, CH_HASH);
		else
			send_item(KIND_CHAR, $urandom_range(0, 1) ? CH_BAR : CH_BRACE);
	endtask

	// result side: random stalls, one long hold-off on request
	initial begin : drain
		int stall;
		result.ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			if (hold_cycles > 0) begin
				result.ready <= 1'b0;
				repeat (hold_cycles) @(posedge clk);
				hold_cycles = 0;
			end else begin
				stall = calm ? 0 : $urandom_range(0, 12);
				if (stall > 0) begin
					result.ready <= 1'b0;
					repeat (stall) @(posedge clk);
				end
			end
			result.ready <= 1'b1;
			@(posedge clk);
			while (!result.valid) @(posedge clk);
		end
	end

	initial begin : stimulus
		int r;
		bit held;
		bit paused;
		held = 1'b0;
		paused = 1'b0;
		item.valid <= 1'b0;
		item.kind <= KIND_CHAR;
		item.char_in <= 8'h00;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// plain bytes, closing characters outside a region
		send_item(KIND_CHAR, 8'h00);
		send_item(KIND_CHAR, 8'hFF);
		send_item(KIND_CHAR, CH_HASH);
		send_item(KIND_CHAR, CH_BAR);
		// hex: full byte, blank, illegal digit, close with leftover bits
		send_item(KIND_HEX, 8'hFF);
		send_item(KIND_CHAR, "f");
		send_item(KIND_CHAR, "F");
		send_item(KIND_CHAR, 8'h20);
		send_item(KIND_CHAR, "g");
		send_item(KIND_CHAR, "a");
		send_item(KIND_CHAR, CH_HASH);
		// hex: close with zero leftover bits
		send_item(KIND_HEX, 8'h00);
		send_item(KIND_CHAR, "0");
		send_item(KIND_CHAR, CH_HASH);
		// base64: top digits, blank, pad, close with leftover bits
		send_item(KIND_B64, 8'h00);
		send_item(KIND_CHAR, "/");
		send_item(KIND_CHAR, 8'h09);
		send_item(KIND_CHAR, "/");
		send_item(KIND_CHAR, CH_PAD);
		send_item(KIND_CHAR, "+");
		send_item(KIND_CHAR, CH_BRACE);
		// reopen while open, wrong closer, end inside a region
		send_item(KIND_B64, 8'h00);
		send_item(KIND_HEX, 8'h00);
		send_item(KIND_CHAR, CH_BAR);
		send_item(KIND_END, 8'hFF);

		while (counted < 1950) begin
			if (!held && counted >= 600) begin
				held = 1'b1;
				hold_cycles = 300;
			end
			if (!paused && counted >= 1200) begin
				paused = 1'b1;
				item.valid <= 1'b0;
				@(posedge clk);
				wait (pending == 0);
				repeat (4) @(posedge clk);
			end
			calm = (counted >= 900 && counted < 1050);
			r = $urandom_range(0, 19);
			if (r < 3)
				repeat ($urandom_range(1, 8)) send_item(KIND_CHAR, 8'($urandom));
			else if (r < 9)
				send_region(KIND_HEX);
			else if (r < 16)
				send_region(KIND_B64);
			else if (r == 16)
				send_item(KIND_END, 8'($urandom));
			else
				send_item(kind_t'($urandom_range(0, 3)), 8'($urandom));
		end
		calm = 1'b0;
		item.valid <= 1'b0;
		@(posedge clk);
		wait (pending == 0);
		repeat (20) @(posedge clk);
		if (errors == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
